// ===== src/reaction_wheel_pendulum_step_assert.svh =====
`ifndef REACTION_WHEEL_PENDULUM_STEP_ASSERT_SVH
`define REACTION_WHEEL_PENDULUM_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk, held off during reset
`define RWP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwp assertion failed");

// next-cycle implication
`define RWP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwp assertion failed");

`endif

// ===== src/rwp_pkg.sv =====
package rwp_pkg;

    localparam int DT_W       = 17;
    localparam int IN_TDATA_W = 24;
    localparam int Q_W        = 32;
    localparam int OUT_TDATA_W = 5 * Q_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int UCFG_W     = 31;

    localparam int NUM_W      = 40;
    localparam int FRAC_W     = 16;
    localparam int DIVD_W     = NUM_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    localparam int MUL_IN_W   = 33;
    localparam int MUL_OUT_W  = 2 * MUL_IN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PEND_MASS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MASS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_INERTIA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_INERTIA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_LENGTH  = 3'd5;

    localparam logic signed [MUL_IN_W-1:0] GAIN_PA = 33'sd26714964;
    localparam logic signed [MUL_IN_W-1:0] GAIN_WA = 33'sd2455097;
    localparam logic signed [MUL_IN_W-1:0] GAIN_PR = 33'sd12411555;
    localparam logic signed [MUL_IN_W-1:0] GAIN_WR = 33'sd2273883;
    localparam logic signed [MUL_IN_W-1:0] INV2PI_Q32 = 33'sd683565276;
    localparam logic signed [MUL_IN_W-1:0] HALFPI_Q30 = 33'sd1686629713;

    localparam logic [30:0] CQ_ONE = 31'd1073741824;
    localparam logic [30:0] CQ_C2  = 31'd536870912;
    localparam logic [30:0] CQ_C4  = 31'd44739243;
    localparam logic [30:0] CQ_C6  = 31'd1491308;
    localparam logic [30:0] CQ_C8  = 31'd26631;

    localparam logic signed [Q_W-1:0] RST_PEND_ANGLE  = -32'sd135712;
    localparam logic signed [Q_W-1:0] RST_WHEEL_ANGLE = 32'sd1114112;

    localparam logic [UCFG_W-1:0]     RST_PEND_MASS    = 31'd65536;
    localparam logic [UCFG_W-1:0]     RST_WHEEL_MASS   = 31'd65536;
    localparam logic [UCFG_W-1:0]     RST_WHEEL_INERTIA = 31'd32768;
    localparam logic [UCFG_W-1:0]     RST_PEND_INERTIA = 31'd32768;
    localparam logic signed [Q_W-1:0] RST_GRAVITY      = -32'sd642908;
    localparam logic [UCFG_W-1:0]     RST_PEND_LENGTH  = 31'd65536;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== src/rwp_mul.sv =====
module rwp_mul (
    input  logic                                  clk,
    input  logic signed [rwp_pkg::MUL_IN_W-1:0]  a,
    input  logic signed [rwp_pkg::MUL_IN_W-1:0]  b,
    output logic signed [rwp_pkg::MUL_OUT_W-1:0] prod
);

    logic signed [rwp_pkg::MUL_OUT_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= rwp_pkg::MUL_OUT_W'(a) * rwp_pkg::MUL_OUT_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== src/rwp_div.sv =====
module rwp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rwp_pkg::div_req_t  req,
    output rwp_pkg::div_rsp_t  rsp
);

    localparam int DW = rwp_pkg::DIVD_W;
    localparam int NW = rwp_pkg::NUM_W;

    logic                              running_reg, running_next;
    logic                              done_reg, done_next;
    logic [rwp_pkg::DIV_CNT_W-1:0]     count_reg, count_next;
    logic [DW-1:0]                     dq_reg, dq_next;
    logic [NW-1:0]                     rem_reg, rem_next;
    logic [NW-1:0]                     dmag_reg, dmag_next;
    logic                              neg_reg, neg_next;

    logic [NW-1:0]   num_mag;
    logic [NW-1:0]   den_mag;
    logic [NW:0]     rem_shift;
    logic [NW+1:0]   diff;

    assign num_mag   = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    assign den_mag   = req.den[NW-1] ? NW'(-req.den) : NW'(req.den);
    assign rem_shift = {rem_reg, dq_reg[DW-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dmag_reg};

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        dmag_next    = dmag_reg;
        neg_next     = neg_reg;
        if (req.start)
        begin
            running_next = 1'b1;
            count_next   = '0;
            dq_next      = {num_mag, {rwp_pkg::FRAC_W{1'b0}}};
            rem_next     = '0;
            dmag_next    = den_mag;
            neg_next     = req.num[NW-1] ^ req.den[NW-1];
        end
        else if (running_reg)
        begin
            if (!diff[NW+1])
            begin
                rem_next = diff[NW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[NW-1:0];
                dq_next  = {dq_reg[DW-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == rwp_pkg::DIV_CNT_W'(DW - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    // truncating quotient, saturated to q16.16
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
        begin
            if (dq_reg > DW'(32'h7fffffff))
                rsp.quot = 32'sh7fffffff;
            else
                rsp.quot = dq_reg[31:0];
        end
        else
        begin
            if (dq_reg > DW'(33'h080000000))
                rsp.quot = 32'sh80000000;
            else
                rsp.quot = -dq_reg[31:0];
        end
    end

endmodule

// ===== src/reaction_wheel_pendulum_step.sv =====
// One time step of a reaction-wheel inverted pendulum per request: state feedback torque,
// cosine of the pendulum angle, closed-form accelerations and a semi-implicit Euler update,
// all in signed q16.16 with saturation. A single registered 33x33 multiplier is reused
// under a microcoded sequencer, and a radix-2 restoring divider forms both accelerations
// one after the other. A step takes the request, runs 37 multiplier passes and two
// divisions of 56 quotient bits each, and loads the result; with a zero denominator the
// divisions are skipped. A step also waits to load its result while the previous result
// is still held back by the receiver.
// A new request is taken only when the previous one is finished; a finished result waits
// in the output register while the next request is taken.
module reaction_wheel_pendulum_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rwp_pkg::IN_TDATA_W-1:0]      s_tdata,   // [16:0] time_step
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rwp_pkg::OUT_TDATA_W-1:0]     m_tdata,   // torque, pendulum_angle,
                                                           // wheel_angle, pendulum_rate,
                                                           // wheel_rate
    output logic                                m_tuser,   // singular
    input  logic                                cfg_we,
    input  logic [rwp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rwp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int MI = rwp_pkg::MUL_IN_W;
    localparam int MO = rwp_pkg::MUL_OUT_W;
    localparam int NW = rwp_pkg::NUM_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CALC = 6'b000010,
        S_DIVP = 6'b000100,
        S_DIVW = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    typedef enum logic [5:0] {
        U_GPA, U_GWA, U_GPR, U_GWR, U_LL,
        U_PH, U_X, U_X2, U_H6, U_H4, U_H2, U_H0,
        U_D_II, U_D_WW, U_D_IW, U_D_IM, U_D_IML, U_D_IMW, U_D_IMWL,
        U_P_G, U_P_L, U_P_C, U_P_T,
        U_W_IT, U_W_WT, U_W_ML, U_W_MLT, U_W_NL, U_W_NLT, U_W_WM, U_W_G, U_W_L, U_W_C,
        U_R_P, U_R_W, U_A_P, U_A_W
    } ucode_t;

    function automatic logic signed [31:0] sat32(input logic signed [MO-1:0] v);
        if (v > MO'(33'sh07fffffff))
            return 32'sh7fffffff;
        else if (v < -MO'(33'sh080000000))
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [30:0] clamp_sub(input logic [30:0] c, input logic [32:0] p);
        if (p > {2'b00, c})
            return '0;
        else
            return c - p[30:0];
    endfunction

    function automatic logic signed [31:0] cos_fin(input logic [30:0] t,
                                                   input logic [1:0] quad);
        logic [31:0] s;
        logic [17:0] m;
        s = {1'b0, t} + 32'd8192;
        m = s[31:14];
        if (m > 18'd65536)
            m = 18'd65536;
        if (quad[1] ^ quad[0])
            return -(32'(m));
        else
            return 32'(m);
    endfunction

    function automatic logic signed [MI-1:0] sx(input logic signed [31:0] v);
        return MI'(v);
    endfunction

    function automatic logic signed [MI-1:0] zx(input logic [30:0] v);
        return {2'b00, v};
    endfunction

    state_t state_reg, state_next;
    ucode_t step_reg, step_next;
    logic   phase_reg, phase_next;

    logic [30:0]        mp_reg, mw_reg, iw_reg, ip_reg, lp_reg;
    logic signed [31:0] g_reg;

    logic signed [31:0] pa_reg, pa_next, wa_reg, wa_next;
    logic signed [31:0] pr_reg, pr_next, wr_reg, wr_next;

    logic [rwp_pkg::DT_W-1:0] dt_reg, dt_next;
    logic signed [31:0] tq_reg, tq_next, l2_reg, l2_next, c_reg, c_next;
    logic signed [31:0] t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic [15:0]        ph_reg, ph_next;
    logic [30:0]        x_reg, x_next, t_reg, t_next;
    logic [31:0]        x2_reg, x2_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [NW-1:0] den_reg, den_next, nump_reg, nump_next, numw_reg, numw_next;
    logic signed [31:0] accp_reg, accp_next, accw_reg, accw_next;
    logic               sing_reg, sing_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [rwp_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;

    logic signed [MI-1:0] mul_a, mul_b;
    logic signed [MO-1:0] prod, prod_sh;
    logic signed [31:0]   qv;
    logic signed [63:0]   qe;
    logic [14:0]          rr;
    logic [30:0]          t_last;
    logic                 s_acc;

    rwp_pkg::div_req_t div_req;
    rwp_pkg::div_rsp_t div_rsp;

    rwp_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rwp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign prod_sh = prod >>> 16;
    assign qv      = sat32(prod_sh);
    assign qe      = 64'(qv);
    assign rr      = ph_reg[14] ? 15'(15'd16384 - {1'b0, ph_reg[13:0]}) : {1'b0, ph_reg[13:0]};
    assign t_last  = clamp_sub(rwp_pkg::CQ_ONE, prod[62:30]);
    assign s_acc   = s_tvalid & s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            U_GPA:    begin mul_a = rwp_pkg::GAIN_PA; mul_b = sx(pa_reg); end
            U_GWA:    begin mul_a = rwp_pkg::GAIN_WA; mul_b = sx(wa_reg); end
            U_GPR:    begin mul_a = rwp_pkg::GAIN_PR; mul_b = sx(pr_reg); end
            U_GWR:    begin mul_a = rwp_pkg::GAIN_WR; mul_b = sx(wr_reg); end
            U_LL:     begin mul_a = zx(lp_reg); mul_b = zx(lp_reg); end
            U_PH:     begin mul_a = sx(pa_reg); mul_b = rwp_pkg::INV2PI_Q32; end
            U_X:      begin mul_a = {18'd0, rr}; mul_b = rwp_pkg::HALFPI_Q30; end
            U_X2:     begin mul_a = zx(x_reg); mul_b = zx(x_reg); end
            U_H6, U_H4, U_H2, U_H0:
                      begin mul_a = {1'b0, x2_reg}; mul_b = zx(t_reg); end
            U_D_II:   begin mul_a = zx(ip_reg); mul_b = zx(ip_reg); end
            U_D_WW:   begin mul_a = zx(iw_reg); mul_b = zx(iw_reg); end
            U_D_IW:   begin mul_a = zx(ip_reg); mul_b = zx(iw_reg); end
            U_D_IM:   begin mul_a = zx(ip_reg); mul_b = zx(mp_reg); end
            U_D_IML:  begin mul_a = sx(t1_reg); mul_b = sx(l2_reg); end
            U_D_IMW:  begin mul_a = zx(ip_reg); mul_b = zx(mw_reg); end
            U_D_IMWL: begin mul_a = sx(t1_reg); mul_b = sx(l2_reg); end
            U_P_G:    begin mul_a = sx(t1_reg); mul_b = sx(g_reg); end
            U_P_L:    begin mul_a = sx(t2_reg); mul_b = zx(lp_reg); end
            U_P_C:    begin mul_a = sx(t2_reg); mul_b = sx(c_reg); end
            U_P_T:    begin mul_a = zx(iw_reg); mul_b = sx(tq_reg); end
            U_W_IT:   begin mul_a = zx(ip_reg); mul_b = sx(tq_reg); end
            U_W_WT:   begin mul_a = zx(iw_reg); mul_b = sx(tq_reg); end
            U_W_ML:   begin mul_a = zx(mp_reg); mul_b = sx(l2_reg); end
            U_W_MLT:  begin mul_a = sx(t1_reg); mul_b = sx(tq_reg); end
            U_W_NL:   begin mul_a = zx(mw_reg); mul_b = sx(l2_reg); end
            U_W_NLT:  begin mul_a = sx(t1_reg); mul_b = sx(tq_reg); end
            U_W_WM:   begin mul_a = zx(iw_reg); mul_b = zx(mw_reg); end
            U_W_G:    begin mul_a = sx(t1_reg); mul_b = sx(g_reg); end
            U_W_L:    begin mul_a = sx(t1_reg); mul_b = zx(lp_reg); end
            U_W_C:    begin mul_a = sx(t1_reg); mul_b = sx(c_reg); end
            U_R_P:    begin mul_a = sx(accp_reg); mul_b = MI'(dt_reg); end
            U_R_W:    begin mul_a = sx(accw_reg); mul_b = MI'(dt_reg); end
            U_A_P:    begin mul_a = sx(pr_reg); mul_b = MI'(dt_reg); end
            U_A_W:    begin mul_a = sx(wr_reg); mul_b = MI'(dt_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // sequencer and write-back
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        phase_next    = phase_reg;
        pa_next       = pa_reg;
        wa_next       = wa_reg;
        pr_next       = pr_reg;
        wr_next       = wr_reg;
        dt_next       = dt_reg;
        tq_next       = tq_reg;
        l2_next       = l2_reg;
        c_next        = c_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        t3_next       = t3_reg;
        ph_next       = ph_reg;
        x_next        = x_reg;
        x2_next       = x2_reg;
        t_next        = t_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        nump_next     = nump_reg;
        numw_next     = numw_reg;
        accp_next     = accp_reg;
        accw_next     = accw_reg;
        sing_next     = sing_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_req.start = 1'b0;
        div_req.num   = (state_reg == S_DIVP) ? numw_reg : nump_reg;
        div_req.den   = den_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    dt_next    = s_tdata[rwp_pkg::DT_W-1:0];
                    step_next  = U_GPA;
                    phase_next = 1'b0;
                    state_next = S_CALC;
                end
            end
            S_CALC, S_UPD:
            begin
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    step_next = ucode_t'(step_reg + 6'd1);
                    case (step_reg)
                        U_GPA:    acc_next = prod[63:0];
                        U_GWA, U_GPR, U_GWR:
                                  acc_next = acc_reg + prod[63:0];
                        U_LL:
                        begin
                            l2_next = qv;
                            tq_next = sat32(MO'(acc_reg) >>> 16);
                        end
                        U_PH:     ph_next = prod[47:32];
                        U_X:      x_next = prod[44:14];
                        U_X2:
                        begin
                            x2_next = prod[61:30];
                            t_next  = rwp_pkg::CQ_C8;
                        end
                        U_H6:     t_next = clamp_sub(rwp_pkg::CQ_C6, prod[62:30]);
                        U_H4:     t_next = clamp_sub(rwp_pkg::CQ_C4, prod[62:30]);
                        U_H2:     t_next = clamp_sub(rwp_pkg::CQ_C2, prod[62:30]);
                        U_H0:     c_next = cos_fin(t_last, ph_reg[15:14]);
                        U_D_II:   acc_next = qe <<< 2;
                        U_D_WW:   acc_next = acc_reg - (qe <<< 2);
                        U_D_IW:   acc_next = acc_reg + (qe <<< 2);
                        U_D_IM:   t1_next = qv;
                        U_D_IML:  acc_next = acc_reg + qe;
                        U_D_IMW:  t1_next = qv;
                        U_D_IMWL:
                        begin
                            acc_next = acc_reg + (qe <<< 2);
                            den_next = acc_next[NW-1:0];
                        end
                        U_P_G:    t2_next = qv;
                        U_P_L:    t2_next = qv;
                        U_P_C:    t3_next = qv;
                        U_P_T:    nump_next = NW'(-((qe + 64'(t3_reg)) <<< 2));
                        U_W_IT:   acc_next = qe <<< 2;
                        U_W_WT:   acc_next = acc_reg + (qe <<< 2);
                        U_W_ML:   t1_next = qv;
                        U_W_MLT:  acc_next = acc_reg + qe;
                        U_W_NL:   t1_next = qv;
                        U_W_NLT:  acc_next = acc_reg + (qe <<< 2);
                        U_W_WM, U_W_G, U_W_L:
                                  t1_next = qv;
                        U_W_C:
                        begin
                            numw_next = NW'(acc_reg + (qe <<< 2));
                            sing_next = (den_reg == '0);
                            if (den_reg == '0)
                            begin
                                accp_next  = '0;
                                accw_next  = '0;
                                state_next = S_UPD;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIVP;
                            end
                        end
                        U_R_P:    pr_next = sat32(MO'(pr_reg) + prod_sh);
                        U_R_W:    wr_next = sat32(MO'(wr_reg) + prod_sh);
                        U_A_P:    pa_next = sat32(MO'(pa_reg) + prod_sh);
                        U_A_W:
                        begin
                            wa_next    = sat32(MO'(wa_reg) + prod_sh);
                            state_next = S_DONE;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_DIVP:
            begin
                if (div_rsp.done)
                begin
                    accp_next     = div_rsp.quot;
                    div_req.start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    accw_next  = div_rsp.quot;
                    phase_next = 1'b0;
                    state_next = S_UPD;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {wr_reg, pr_reg, wa_reg, pa_reg, tq_reg};
                    m_tuser_next  = sing_reg;
                    state_next    = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= U_GPA;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pa_reg       <= rwp_pkg::RST_PEND_ANGLE;
            wa_reg       <= rwp_pkg::RST_WHEEL_ANGLE;
            pr_reg       <= '0;
            wr_reg       <= '0;
            mp_reg       <= rwp_pkg::RST_PEND_MASS;
            mw_reg       <= rwp_pkg::RST_WHEEL_MASS;
            iw_reg       <= rwp_pkg::RST_WHEEL_INERTIA;
            ip_reg       <= rwp_pkg::RST_PEND_INERTIA;
            g_reg        <= rwp_pkg::RST_GRAVITY;
            lp_reg       <= rwp_pkg::RST_PEND_LENGTH;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            pa_reg       <= pa_next;
            wa_reg       <= wa_next;
            pr_reg       <= pr_next;
            wr_reg       <= wr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rwp_pkg::CFG_PEND_MASS:     mp_reg <= cfg_data[30:0];
                    rwp_pkg::CFG_WHEEL_MASS:    mw_reg <= cfg_data[30:0];
                    rwp_pkg::CFG_WHEEL_INERTIA: iw_reg <= cfg_data[30:0];
                    rwp_pkg::CFG_PEND_INERTIA:  ip_reg <= cfg_data[30:0];
                    rwp_pkg::CFG_GRAVITY:       g_reg  <= cfg_data;
                    rwp_pkg::CFG_PEND_LENGTH:   lp_reg <= cfg_data[30:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg      <= dt_next;
        tq_reg      <= tq_next;
        l2_reg      <= l2_next;
        c_reg       <= c_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        ph_reg      <= ph_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        den_reg     <= den_next;
        nump_reg    <= nump_next;
        numw_reg    <= numw_next;
        accp_reg    <= accp_next;
        accw_reg    <= accw_next;
        sing_reg    <= sing_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// ===== src/rwp_chk.sv =====
`include "reaction_wheel_pendulum_step_assert.svh"

module rwp_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rwp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // a request that is taken keeps the block busy
    `RWP_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    // a result appears only as the block goes back to waiting for a request
    `RWP_ASSERT_NOW(a_ready_at_result, $rose(m_tvalid), s_tready)
    `RWP_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid)
    `RWP_ASSERT_NEXT(a_data_holds, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind reaction_wheel_pendulum_step rwp_chk u_rwp_chk (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;

    typedef struct packed {
        logic signed [31:0] torque;
        logic signed [31:0] pend_angle;
        logic signed [31:0] wheel_angle;
        logic signed [31:0] pend_rate;
        logic signed [31:0] wheel_rate;
        logic               singular;
    } step_result_t;

    class step_scoreboard;
        step_result_t pending[$];
        int unsigned  mismatches;

        function void note_request(step_result_t r);
            pending.insert(pending.size(), r);
        endfunction

        task check_result(step_result_t got);
            step_result_t exp_r;
            if (pending.size() == 0)
            begin
                report_mismatch("result with none pending", 0, 0);
                return;
            end
            exp_r = pending.pop_front();
            if (got.torque !== exp_r.torque)
                report_mismatch("torque", got.torque, exp_r.torque);
            if (got.pend_angle !== exp_r.pend_angle)
                report_mismatch("pendulum_angle", got.pend_angle, exp_r.pend_angle);
            if (got.wheel_angle !== exp_r.wheel_angle)
                report_mismatch("wheel_angle", got.wheel_angle, exp_r.wheel_angle);
            if (got.pend_rate !== exp_r.pend_rate)
                report_mismatch("pendulum_rate", got.pend_rate, exp_r.pend_rate);
            if (got.wheel_rate !== exp_r.wheel_rate)
                report_mismatch("wheel_rate", got.wheel_rate, exp_r.wheel_rate);
            if (got.singular !== exp_r.singular)
                report_mismatch("singular", got.singular, exp_r.singular);
        endtask

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            mismatches++;
        endtask
    endclass

    logic                                 clk = 0;
    logic                                 rst_n = 0;
    logic                                 s_tvalid = 0;
    logic                                 s_tready;
    logic [rwp_pkg::IN_TDATA_W-1:0]       s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 0;
    logic [rwp_pkg::OUT_TDATA_W-1:0]      m_tdata;
    logic                                 m_tuser;
    logic                                 cfg_we = 0;
    logic [rwp_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [rwp_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    reaction_wheel_pendulum_step u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    step_scoreboard sb = new();

    // predictor copy of the plant
    longint mdl_mp, mdl_mw, mdl_iw, mdl_ip, mdl_g, mdl_l;
    longint mdl_pa, mdl_wa, mdl_pr, mdl_wr;

    bit     no_idle = 0;
    bit     hold_off = 0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 3000000;

    function automatic longint fshr(longint v);
        return v >>> 16;
    endfunction

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qm(longint a, longint b);
        return sat((a * b) >>> 16);
    endfunction

    function automatic longint unsigned clamp_sub(longint unsigned a, longint unsigned b);
        return (b > a) ? 0 : a - b;
    endfunction

    function automatic longint unsigned quarter_cos(longint unsigned r);
        longint unsigned x, x2, t;
        x = (r * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        t = 26631;
        t = clamp_sub(1491308, (x2 * t) >> 30);
        t = clamp_sub(44739243, (x2 * t) >> 30);
        t = clamp_sub(536870912, (x2 * t) >> 30);
        t = clamp_sub(1073741824, (x2 * t) >> 30);
        return t;
    endfunction

    function automatic longint cosine(longint ang);
        longint           prod;
        longint unsigned  c;
        logic [15:0]      ph;
        logic [1:0]       q;
        longint unsigned  r;
        prod = ang * 64'sd683565276;
        ph = prod[47:32];
        q = ph[15:14];
        r = ph[13:0];
        c = (q == 0 || q == 2) ? quarter_cos(r) : quarter_cos(16384 - r);
        c = (c + 8192) >> 14;
        if (c > 65536)
            c = 65536;
        return (q == 1 || q == 2) ? -longint'(c) : longint'(c);
    endfunction

    function automatic longint divq(longint num, longint den);
        longint n, d, qv;
        // truncating division, magnitudes stay within 63 bits
        n = num * 65536;
        qv = n / den;
        d = 0;
        return sat(qv + d);
    endfunction

    function automatic step_result_t predict_step(longint dt);
        step_result_t res;
        longint tq, c, l2, den, np, nw, ap, aw;
        ap = 0;
        aw = 0;
        tq = sat(fshr(64'sd26714964 * mdl_pa + 64'sd2455097 * mdl_wa
                      + 64'sd12411555 * mdl_pr + 64'sd2273883 * mdl_wr));
        c = cosine(mdl_pa);
        l2 = qm(mdl_l, mdl_l);
        den = 4 * qm(mdl_ip, mdl_ip) - 4 * qm(mdl_iw, mdl_iw) + 4 * qm(mdl_ip, mdl_iw)
            + qm(qm(mdl_ip, mdl_mp), l2) + 4 * qm(qm(mdl_ip, mdl_mw), l2);
        np = -4 * (qm(mdl_iw, tq) + qm(qm(qm(qm(mdl_ip, mdl_mw), mdl_g), mdl_l), c));
        nw = 4 * qm(mdl_ip, tq) + 4 * qm(mdl_iw, tq) + qm(qm(mdl_mp, l2), tq)
           + 4 * qm(qm(mdl_mw, l2), tq) + 4 * qm(qm(qm(qm(mdl_iw, mdl_mw), mdl_g), mdl_l), c);
        if (den != 0)
        begin
            ap = divq(np, den);
            aw = divq(nw, den);
        end
        mdl_pr = sat(mdl_pr + fshr(ap * dt));
        mdl_wr = sat(mdl_wr + fshr(aw * dt));
        mdl_pa = sat(mdl_pa + fshr(mdl_pr * dt));
        mdl_wa = sat(mdl_wa + fshr(mdl_wr * dt));
        res.torque = tq;
        res.pend_angle = mdl_pa;
        res.wheel_angle = mdl_wa;
        res.pend_rate = mdl_pr;
        res.wheel_rate = mdl_wr;
        res.singular = (den == 0);
        return res;
    endfunction

    function automatic void model_config(logic [rwp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        longint u;
        u = v[30:0];
        case (idx)
            rwp_pkg::CFG_PEND_MASS:     mdl_mp = u;
            rwp_pkg::CFG_WHEEL_MASS:    mdl_mw = u;
            rwp_pkg::CFG_WHEEL_INERTIA: mdl_iw = u;
            rwp_pkg::CFG_PEND_INERTIA:  mdl_ip = u;
            rwp_pkg::CFG_GRAVITY:       mdl_g = longint'(signed'(v));
            rwp_pkg::CFG_PEND_LENGTH:   mdl_l = u;
            default: ;
        endcase
    endfunction

    task automatic write_reg(logic [rwp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        model_config(idx, v);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic send_step(logic [16:0] dt);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {7'b0, dt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(predict_step(dt));
    endtask

    function automatic logic [16:0] random_dt();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return 17'($urandom_range(1, 2000));
        if (k < 85)
            return 17'($urandom_range(0, 65536));
        return 17'($urandom_range(0, 131071));
    endfunction

    // receiver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (m_tvalid && m_tready)
            sb.check_result(step_result_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                            m_tdata[127:96], m_tdata[159:128], m_tuser}));
        if (hold_off)
            m_tready <= 0;
        else
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("reaction_wheel_pendulum_step regression: fail");
            $finish;
        end
    end

    initial
    begin
        mdl_mp = 65536; mdl_mw = 65536; mdl_iw = 32768; mdl_ip = 32768;
        mdl_g = -642908; mdl_l = 65536;
        mdl_pa = -135712; mdl_wa = 1114112; mdl_pr = 0; mdl_wr = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: time step extremes at reset settings
        send_step(0);
        send_step(17'd1);
        send_step(17'd65536);
        send_step(17'd131071);
        send_step(17'h0AAAA);
        send_step(17'h15555);
        wait_drained();

        // zero denominator: all inertias, masses and length zero
        write_reg(rwp_pkg::CFG_PEND_INERTIA, 0);
        write_reg(rwp_pkg::CFG_WHEEL_INERTIA, 0);
        write_reg(rwp_pkg::CFG_PEND_MASS, 0);
        write_reg(rwp_pkg::CFG_WHEEL_MASS, 0);
        write_reg(rwp_pkg::CFG_PEND_LENGTH, 0);
        write_reg(rwp_pkg::CFG_GRAVITY, 32'h80000000);
        send_step(17'd1000);
        send_step(17'd65536);
        wait_drained();

        // extremes, out-of-range data bits and ignored indices
        write_reg(rwp_pkg::CFG_PEND_INERTIA, 32'hFFFFFFFF);
        write_reg(rwp_pkg::CFG_WHEEL_INERTIA, 32'h7FFFFFFF);
        write_reg(rwp_pkg::CFG_PEND_MASS, 32'hFFFFFFFF);
        write_reg(rwp_pkg::CFG_WHEEL_MASS, 32'h7FFFFFFF);
        write_reg(rwp_pkg::CFG_PEND_LENGTH, 32'hFFFFFFFF);
        write_reg(rwp_pkg::CFG_GRAVITY, 32'h7FFFFFFF);
        write_reg(3'd6, 32'h12345678);
        write_reg(3'd7, 32'hFFFFFFFF);
        send_step(17'd100);
        send_step(17'd131071);
        send_step(17'd0);
        wait_drained();

        // random phases across several settings
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(rwp_pkg::CFG_PEND_MASS, 65536);
                write_reg(rwp_pkg::CFG_WHEEL_MASS, 65536);
                write_reg(rwp_pkg::CFG_WHEEL_INERTIA, 32768);
                write_reg(rwp_pkg::CFG_PEND_INERTIA, 32768);
                write_reg(rwp_pkg::CFG_GRAVITY, -32'sd642908);
                write_reg(rwp_pkg::CFG_PEND_LENGTH, 65536);
            end
            else
            begin
                for (int r = 0; r < 6; r++)
                    write_reg(r[rwp_pkg::CFG_IDX_W-1:0],
                              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 300000)
                              | ($urandom_range(1) ? 32'h80000000 : 0));
            end
            no_idle = (ph == 2);
            if (ph == 4)
                fork
                    begin
                        hold_off = 1;
                        repeat (2000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int i = 0; i < 95; i++)
                send_step(random_dt());
            wait_drained();
        end
        no_idle = 0;

        if (sb.mismatches == 0)
            $display("reaction_wheel_pendulum_step regression: pass");
        else
            $display("reaction_wheel_pendulum_step regression: fail");
        $finish;
    end
endmodule
